/* hdl/qpgtl_pkg.sv */
package qpgtl_pkg;

  localparam int NumStages = 6;

  typedef enum logic [1:0] {
    ModeIdle   = 2'd0,
    ModeRail   = 2'd1,
    ModeLaunch = 2'd2,
    ModeCoast  = 2'd3
  } flight_mode_e;

  typedef enum logic [2:0] {
    RegAttitudeGain  = 3'd0,
    RegRateGain      = 3'd1,
    RegAltitudeGain  = 3'd2,
    RegClimbRateGain = 3'd3,
    RegGravity       = 3'd4,
    RegTargetAlt     = 3'd5,
    RegDryMass       = 3'd6
  } reg_idx_e;

  localparam logic [15:0]        AttitudeGainRst  = 16'd26;
  localparam logic [15:0]        RateGainRst      = 16'd179;
  localparam logic [15:0]        AltitudeGainRst  = 16'd2560;
  localparam logic [15:0]        ClimbRateGainRst = 16'd5120;
  localparam logic [15:0]        GravityRst       = 16'd2511;
  localparam logic signed [23:0] TargetAltRst     = 24'sd5120;
  localparam logic [23:0]        DryMassRst       = 24'd0;

  // 1.0 in the rotation matrix format (2^-28)
  localparam logic signed [33:0] RotOne = 34'sh010000000;

  // both saturators take the rounded sum cut to 37 bits
  function automatic logic signed [15:0] sat_angle(input logic signed [36:0] v);
    logic signed [15:0] r;
    if (v > 37'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -37'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_thrust(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/quaternion_pd_gimbal_thrust_law.sv */
// PD attitude and altitude thrust law. Each request carries a flight mode, an attitude
// quaternion (value/16384), world angular rates (value/2048 rad/s), altitude, climb rate and
// propellant mass; it yields outer and inner gimbal angles (value/16384 rad) and a thrust
// command (1/256 N), all rounded half up and saturated. Idle requests are dropped, coast
// requests return all zeros. The datapath is a six-stage pipeline: quaternion products and
// thrust terms, rotation matrix entries, body rate products, body rate rounding, gimbal sums,
// final rounding into the output register. A request enters every cycle unless all stages
// are full; each stage holds only while the stage after it is full and stalled, so
// the block keeps taking requests into empty stages while a result waits. Gains and set points
// sit in an APB register file (byte addresses 0x00..0x18) and may be changed only when idle.
module quaternion_pd_gimbal_thrust_law_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         flight_mode_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  input  logic signed [15:0] rate_z_i,
  input  logic signed [23:0] altitude_i,
  input  logic signed [23:0] climb_rate_i,
  input  logic [23:0]        propellant_mass_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] outer_gimbal_o,
  output logic signed [15:0] inner_gimbal_o,
  output logic signed [31:0] thrust_o
);

  localparam int NS = qpgtl_pkg::NumStages;

  // ---------------- register file ----------------
  logic [15:0]        att_gain_q, rate_gain_q, alt_gain_q, climb_gain_q, gravity_q;
  logic signed [23:0] target_alt_q;
  logic [23:0]        dry_mass_q;
  logic               cfg_wr;
  qpgtl_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = qpgtl_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_gain_q   <= qpgtl_pkg::AttitudeGainRst;
      rate_gain_q  <= qpgtl_pkg::RateGainRst;
      alt_gain_q   <= qpgtl_pkg::AltitudeGainRst;
      climb_gain_q <= qpgtl_pkg::ClimbRateGainRst;
      gravity_q    <= qpgtl_pkg::GravityRst;
      target_alt_q <= qpgtl_pkg::TargetAltRst;
      dry_mass_q   <= qpgtl_pkg::DryMassRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        qpgtl_pkg::RegAttitudeGain:  att_gain_q   <= pwdata[15:0];
        qpgtl_pkg::RegRateGain:      rate_gain_q  <= pwdata[15:0];
        qpgtl_pkg::RegAltitudeGain:  alt_gain_q   <= pwdata[15:0];
        qpgtl_pkg::RegClimbRateGain: climb_gain_q <= pwdata[15:0];
        qpgtl_pkg::RegGravity:       gravity_q    <= pwdata[15:0];
        qpgtl_pkg::RegTargetAlt:     target_alt_q <= pwdata[23:0];
        qpgtl_pkg::RegDryMass:       dry_mass_q   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      qpgtl_pkg::RegAttitudeGain:  prdata = {16'd0, att_gain_q};
      qpgtl_pkg::RegRateGain:      prdata = {16'd0, rate_gain_q};
      qpgtl_pkg::RegAltitudeGain:  prdata = {16'd0, alt_gain_q};
      qpgtl_pkg::RegClimbRateGain: prdata = {16'd0, climb_gain_q};
      qpgtl_pkg::RegGravity:       prdata = {16'd0, gravity_q};
      qpgtl_pkg::RegTargetAlt:     prdata = {{8{target_alt_q[23]}}, target_alt_q};
      qpgtl_pkg::RegDryMass:       prdata = {8'd0, dry_mass_q};
      default:                     prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic [NS-1:0] vld_q, vld_d, coast_q, coast_d, stage_en;

  always_comb begin
    stage_en[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      stage_en[k] = !vld_q[k] || stage_en[k+1];
    end
  end

  assign in_ready_o = stage_en[0];

  always_comb begin
    vld_d   = vld_q;
    coast_d = coast_q;
    if (stage_en[0]) begin
      // drop idle requests at the door
      vld_d[0]   = in_valid_i && (flight_mode_i != qpgtl_pkg::ModeIdle);
      coast_d[0] = flight_mode_i == qpgtl_pkg::ModeCoast;
    end
    for (int k = 1; k < NS; k++) begin
      if (stage_en[k]) begin
        vld_d[k]   = vld_q[k-1];
        coast_d[k] = coast_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      coast_q <= '0;
    end else begin
      vld_q   <= vld_d;
      coast_q <= coast_d;
    end
  end

  // ---------------- stage 1: quaternion products, thrust terms ----------------
  logic signed [31:0] p_xx_q, p_yy_q, p_zz_q, p_xy_q, p_zw_q, p_xz_q, p_yw_q, p_yz_q, p_xw_q;
  logic signed [15:0] wx_s1_q, wy_s1_q, wz_s1_q;
  logic signed [32:0] ax_s1_q, ay_s1_q;
  logic signed [42:0] ta_q, tg_q, tc_q;
  logic signed [24:0] alt_err;
  logic [24:0]        mass_sum;

  assign alt_err  = {target_alt_q[23], target_alt_q} - {altitude_i[23], altitude_i};
  assign mass_sum = {1'b0, propellant_mass_i} + {1'b0, dry_mass_q};

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      p_xx_q  <= quat_x_i * quat_x_i;
      p_yy_q  <= quat_y_i * quat_y_i;
      p_zz_q  <= quat_z_i * quat_z_i;
      p_xy_q  <= quat_x_i * quat_y_i;
      p_zw_q  <= quat_z_i * quat_w_i;
      p_xz_q  <= quat_x_i * quat_z_i;
      p_yw_q  <= quat_y_i * quat_w_i;
      p_yz_q  <= quat_y_i * quat_z_i;
      p_xw_q  <= quat_x_i * quat_w_i;
      wx_s1_q <= rate_x_i;
      wy_s1_q <= rate_y_i;
      wz_s1_q <= rate_z_i;
      ax_s1_q <= $signed({1'b0, att_gain_q}) * quat_x_i;
      ay_s1_q <= $signed({1'b0, att_gain_q}) * quat_y_i;
      ta_q    <= $signed({1'b0, alt_gain_q}) * alt_err;
      tg_q    <= $signed({1'b0, gravity_q}) * $signed({1'b0, mass_sum});
      tc_q    <= $signed({1'b0, climb_gain_q}) * climb_rate_i;
    end
  end

  // ---------------- stage 2: rotation matrix columns, thrust sum ----------------
  logic signed [33:0] r00_q, r10_q, r20_q, r01_q, r11_q, r21_q;
  logic signed [15:0] wx_s2_q, wy_s2_q, wz_s2_q;
  logic signed [32:0] ax_s2_q, ay_s2_q;
  logic signed [44:0] thr_sum_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      r00_q     <= qpgtl_pkg::RotOne - ((34'(p_yy_q) + 34'(p_zz_q)) <<< 1);
      r10_q     <= (34'(p_xy_q) + 34'(p_zw_q)) <<< 1;
      r20_q     <= (34'(p_xz_q) - 34'(p_yw_q)) <<< 1;
      r01_q     <= (34'(p_xy_q) - 34'(p_zw_q)) <<< 1;
      r11_q     <= qpgtl_pkg::RotOne - ((34'(p_xx_q) + 34'(p_zz_q)) <<< 1);
      r21_q     <= (34'(p_yz_q) + 34'(p_xw_q)) <<< 1;
      wx_s2_q   <= wx_s1_q;
      wy_s2_q   <= wy_s1_q;
      wz_s2_q   <= wz_s1_q;
      ax_s2_q   <= ax_s1_q;
      ay_s2_q   <= ay_s1_q;
      thr_sum_q <= 45'(ta_q) + 45'(tg_q) - 45'(tc_q);
    end
  end

  // ---------------- stage 3: body rate products, thrust rounding ----------------
  logic signed [49:0] m00_q, m10_q, m20_q, m01_q, m11_q, m21_q;
  logic signed [32:0] ax_s3_q, ay_s3_q;
  logic signed [31:0] thr_s3_q;
  logic signed [44:0] thr_rnd;

  assign thr_rnd = (thr_sum_q + 45'sd128) >>> 8;

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      m00_q    <= r00_q * wx_s2_q;
      m10_q    <= r10_q * wy_s2_q;
      m20_q    <= r20_q * wz_s2_q;
      m01_q    <= r01_q * wx_s2_q;
      m11_q    <= r11_q * wy_s2_q;
      m21_q    <= r21_q * wz_s2_q;
      ax_s3_q  <= ax_s2_q;
      ay_s3_q  <= ay_s2_q;
      thr_s3_q <= qpgtl_pkg::sat_thrust(thr_rnd[36:0]);
    end
  end

  // ---------------- stage 4: body rates rounded to 2^-22 ----------------
  logic signed [51:0] bsum0, bsum1, brnd0, brnd1;
  logic signed [34:0] b0_q, b1_q;
  logic signed [32:0] ax_s4_q, ay_s4_q;
  logic signed [31:0] thr_s4_q;

  assign bsum0 = 52'(m00_q) + 52'(m10_q) + 52'(m20_q);
  assign bsum1 = 52'(m01_q) + 52'(m11_q) + 52'(m21_q);
  assign brnd0 = (bsum0 + 52'sd65536) >>> 17;
  assign brnd1 = (bsum1 + 52'sd65536) >>> 17;

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      b0_q     <= brnd0[34:0];
      b1_q     <= brnd1[34:0];
      ax_s4_q  <= ax_s3_q;
      ay_s4_q  <= ay_s3_q;
      thr_s4_q <= thr_s3_q;
    end
  end

  // ---------------- stage 5: gimbal sums at 2^-30 ----------------
  logic signed [52:0] outer_sum_q, inner_sum_q;
  logic signed [31:0] thr_s5_q;
  logic signed [16:0] rate_gain_s;
  logic signed [51:0] outer_rate, inner_rate;

  assign rate_gain_s = $signed({1'b0, rate_gain_q});
  assign outer_rate  = rate_gain_s * b0_q;
  assign inner_rate  = rate_gain_s * b1_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      outer_sum_q <= (53'(ax_s4_q) <<< 8) + 53'(outer_rate);
      inner_sum_q <= (53'(ay_s4_q) <<< 8) + 53'(inner_rate);
      thr_s5_q    <= thr_s4_q;
    end
  end

  // ---------------- stage 6: round, saturate, output register ----------------
  logic signed [52:0] outer_rnd, inner_rnd;
  logic signed [15:0] outer_q, inner_q;
  logic signed [31:0] thrust_q;

  assign outer_rnd = (outer_sum_q + 53'sd32768) >>> 16;
  assign inner_rnd = (inner_sum_q + 53'sd32768) >>> 16;

  always_ff @(posedge clk_i) begin
    if (stage_en[5]) begin
      // coast: zero the whole result
      if (coast_q[4]) begin
        outer_q  <= '0;
        inner_q  <= '0;
        thrust_q <= '0;
      end else begin
        outer_q  <= qpgtl_pkg::sat_angle(outer_rnd[36:0]);
        inner_q  <= qpgtl_pkg::sat_angle(inner_rnd[36:0]);
        thrust_q <= thr_s5_q;
      end
    end
  end

  assign out_valid_o    = vld_q[NS-1];
  assign outer_gimbal_o = outer_q;
  assign inner_gimbal_o = inner_q;
  assign thrust_o       = thrust_q;

`ifndef SYNTHESIS
  a_coast_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && coast_q[NS-1] |-> outer_gimbal_o == 16'sd0 && inner_gimbal_o == 16'sd0
                                     && thrust_o == 32'sd0)
    else $error("coast result not zero");

  a_idle_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && flight_mode_i == qpgtl_pkg::ModeIdle |=> !vld_q[0])
    else $error("idle request entered pipeline");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> &vld_q)
    else $error("input blocked with an empty stage");

  a_rate_gain_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && cfg_idx == qpgtl_pkg::RegRateGain |=> rate_gain_q == $past(pwdata[15:0]))
    else $error("rate gain write lost");
`endif

endmodule

/* sim/quaternion_pd_gimbal_thrust_law_core_tb.sv */
module quaternion_pd_gimbal_thrust_law_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] UnmappedAddr = 5'h1c;

  typedef struct {
    qpgtl_pkg::flight_mode_e mode;
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [15:0] wx, wy, wz;
    logic signed [23:0] alt, climb;
    logic [23:0]        prop;
  } state_sample_t;

  typedef struct {
    logic signed [15:0] outer;
    logic signed [15:0] inner;
    logic signed [31:0] thrust;
  } gimbal_cmd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         flight_mode_i = '0;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic signed [15:0] rate_x_i = '0;
  logic signed [15:0] rate_y_i = '0;
  logic signed [15:0] rate_z_i = '0;
  logic signed [23:0] altitude_i = '0;
  logic signed [23:0] climb_rate_i = '0;
  logic [23:0]        propellant_mass_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] outer_gimbal_o;
  logic signed [15:0] inner_gimbal_o;
  logic signed [31:0] thrust_o;

  // gains and set points as the block should hold them
  logic [15:0]        k_att = qpgtl_pkg::AttitudeGainRst;
  logic [15:0]        k_rate = qpgtl_pkg::RateGainRst;
  logic [15:0]        k_alt = qpgtl_pkg::AltitudeGainRst;
  logic [15:0]        k_climb = qpgtl_pkg::ClimbRateGainRst;
  logic [15:0]        g_accel = qpgtl_pkg::GravityRst;
  logic signed [23:0] alt_setpoint = qpgtl_pkg::TargetAltRst;
  logic [23:0]        mass_dry = qpgtl_pkg::DryMassRst;

  gimbal_cmd_t pending_cmds[$];
  int unsigned fail_count = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;

  quaternion_pd_gimbal_thrust_law_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .flight_mode_i    (flight_mode_i),
    .quat_w_i         (quat_w_i),
    .quat_x_i         (quat_x_i),
    .quat_y_i         (quat_y_i),
    .quat_z_i         (quat_z_i),
    .rate_x_i         (rate_x_i),
    .rate_y_i         (rate_y_i),
    .rate_z_i         (rate_z_i),
    .altitude_i       (altitude_i),
    .climb_rate_i     (climb_rate_i),
    .propellant_mass_i(propellant_mass_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .outer_gimbal_o   (outer_gimbal_o),
    .inner_gimbal_o   (inner_gimbal_o),
    .thrust_o         (thrust_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // divide by 2^n, ties go up
  function automatic longint round_half_up(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic gimbal_cmd_t predict_command(input state_sample_t s);
    longint      qw, qx, qy, qz, wx, wy, wz, one;
    longint      r00, r10, r20, r01, r11, r21;
    longint      b0, b1, outer, inner, thr;
    gimbal_cmd_t c;
    c.outer = '0;
    c.inner = '0;
    c.thrust = '0;
    if (s.mode == qpgtl_pkg::ModeCoast) return c;
    qw = longint'(s.qw);
    qx = longint'(s.qx);
    qy = longint'(s.qy);
    qz = longint'(s.qz);
    wx = longint'(s.wx);
    wy = longint'(s.wy);
    wz = longint'(s.wz);
    one = longint'(1) << 28;
    // first two columns of the rotation matrix, scale 2^-28
    r00 = one - 2 * (qy * qy + qz * qz);
    r10 = 2 * (qx * qy + qz * qw);
    r20 = 2 * (qx * qz - qy * qw);
    r01 = 2 * (qx * qy - qz * qw);
    r11 = one - 2 * (qx * qx + qz * qz);
    r21 = 2 * (qy * qz + qx * qw);
    b0 = round_half_up(r00 * wx + r10 * wy + r20 * wz, 17);
    b1 = round_half_up(r01 * wx + r11 * wy + r21 * wz, 17);
    outer = longint'(k_att) * qx * 256 + longint'(k_rate) * b0;
    inner = longint'(k_att) * qy * 256 + longint'(k_rate) * b1;
    outer = clip(round_half_up(outer, 16), -32768, 32767);
    inner = clip(round_half_up(inner, 16), -32768, 32767);
    thr = longint'(k_alt) * (longint'(alt_setpoint) - longint'(s.alt))
        + longint'(g_accel) * (longint'(s.prop) + longint'(mass_dry))
        - longint'(k_climb) * longint'(s.climb);
    thr = clip(round_half_up(thr, 8), -longint'(2147483647) - 1, longint'(2147483647));
    c.outer = outer[15:0];
    c.inner = inner[15:0];
    c.thrust = thr[31:0];
    return c;
  endfunction

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic cmp_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // handshake signals are stable between the falling edge and the next rising edge
  always @(negedge clk_i) begin
    gimbal_cmd_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                 $time, outer_gimbal_o, inner_gimbal_o, thrust_o);
        fail_count++;
      end else begin
        want = pending_cmds.pop_front();
        cmp_field("outer_gimbal", longint'(want.outer), longint'(outer_gimbal_o));
        cmp_field("inner_gimbal", longint'(want.inner), longint'(inner_gimbal_o));
        cmp_field("thrust", longint'(want.thrust), longint'(thrust_o));
      end
    end
  end

  task automatic send_sample(input state_sample_t s);
    logic taken;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    flight_mode_i     <= s.mode;
    quat_w_i          <= s.qw;
    quat_x_i          <= s.qx;
    quat_y_i          <= s.qy;
    quat_z_i          <= s.qz;
    rate_x_i          <= s.wx;
    rate_y_i          <= s.wy;
    rate_z_i          <= s.wz;
    altitude_i        <= s.alt;
    climb_rate_i      <= s.climb;
    propellant_mass_i <= s.prop;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    if (s.mode != qpgtl_pkg::ModeIdle) pending_cmds.push_back(predict_command(s));
  endtask

  // drop valid, wait for every result and let the pipeline drain
  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (qpgtl_pkg::NumStages + 2) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [4:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input qpgtl_pkg::reg_idx_e idx, input logic [31:0] data);
    apb_write({idx, 2'b00}, data);
    case (idx)
      qpgtl_pkg::RegAttitudeGain:  k_att = data[15:0];
      qpgtl_pkg::RegRateGain:      k_rate = data[15:0];
      qpgtl_pkg::RegAltitudeGain:  k_alt = data[15:0];
      qpgtl_pkg::RegClimbRateGain: k_climb = data[15:0];
      qpgtl_pkg::RegGravity:       g_accel = data[15:0];
      qpgtl_pkg::RegTargetAlt:     alt_setpoint = data[23:0];
      qpgtl_pkg::RegDryMass:       mass_dry = data[23:0];
      default: ;
    endcase
  endtask

  function automatic state_sample_t make_sample(
    input qpgtl_pkg::flight_mode_e m,
    input logic signed [15:0] qw, qx, qy, qz, wx, wy, wz,
    input logic signed [23:0] alt, climb,
    input logic [23:0] prop
  );
    state_sample_t s;
    s.mode = m;
    s.qw = qw;
    s.qx = qx;
    s.qy = qy;
    s.qz = qz;
    s.wx = wx;
    s.wy = wy;
    s.wz = wz;
    s.alt = alt;
    s.climb = climb;
    s.prop = prop;
    return s;
  endfunction

  // random value whose magnitude spans every scale of the field
  function automatic logic signed [15:0] rand_s16();
    logic signed [15:0] r;
    r = 16'($urandom);
    return r >>> $urandom_range(15);
  endfunction

  function automatic logic signed [23:0] rand_s24();
    logic signed [23:0] r;
    r = 24'($urandom);
    return r >>> $urandom_range(23);
  endfunction

  function automatic state_sample_t rand_sample();
    state_sample_t s;
    int unsigned   pick;
    logic [23:0]   p;
    pick = $urandom_range(99);
    if (pick < 10) s.mode = qpgtl_pkg::ModeIdle;
    else if (pick < 20) s.mode = qpgtl_pkg::ModeCoast;
    else if (pick < 60) s.mode = qpgtl_pkg::ModeRail;
    else s.mode = qpgtl_pkg::ModeLaunch;
    s.qw = rand_s16();
    s.qx = rand_s16();
    s.qy = rand_s16();
    s.qz = rand_s16();
    s.wx = rand_s16();
    s.wy = rand_s16();
    s.wz = rand_s16();
    s.alt = rand_s24();
    s.climb = rand_s24();
    p = 24'($urandom);
    s.prop = p >> $urandom_range(23);
    return s;
  endfunction

  // upper bus bits stay random, the register must ignore them
  function automatic logic [31:0] rand_reg_word(input int bits);
    logic [31:0]        raw, mask;
    logic signed [31:0] fld;
    raw = $urandom;
    mask = (32'd1 << bits) - 32'd1;
    fld = $signed(raw << (32 - bits)) >>> (32 - bits + $urandom_range(bits - 1));
    return (raw & ~mask) | (fld & mask);
  endfunction

  // saturating and corner requests, reused under several register settings
  task automatic send_corner_samples();
    send_sample(make_sample(qpgtl_pkg::ModeRail, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                            16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 24'sh7fffff,
                            24'sh7fffff, 24'hffffff));
    send_sample(make_sample(qpgtl_pkg::ModeLaunch, 16'sh8000, 16'sh8000, 16'sh8000,
                            16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 24'sh800000,
                            24'sh800000, 24'h000000));
    send_sample(make_sample(qpgtl_pkg::ModeRail, 16'sh8000, 16'sh7fff, 16'sh8000,
                            16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 24'sh800000,
                            24'sh7fffff, 24'hffffff));
    send_sample(make_sample(qpgtl_pkg::ModeLaunch, 16'sd16384, 0, 0, 0, 16'sd2048,
                            -16'sd2048, 16'sd1000, 0, 0, 24'd2560));
  endtask

  task automatic test_reset_defaults();
    gap_pct = 0;
    stall_pct = 0;
    send_sample(make_sample(qpgtl_pkg::ModeIdle, 16'sd16384, 16'sd100, -16'sd100, 0,
                            16'sd5, 0, 0, 24'sd256, 0, 24'd256));
    send_sample(make_sample(qpgtl_pkg::ModeCoast, 16'sh7fff, 16'sh8000, 16'sh7fff,
                            16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 24'sh7fffff,
                            24'sh800000, 24'hffffff));
    send_corner_samples();
    // 45 degree tilt about x, then about y
    send_sample(make_sample(qpgtl_pkg::ModeRail, 16'sd15137, 16'sd6270, 0, 0, 16'sd512,
                            16'sd1024, -16'sd300, 24'sd1280, -24'sd512, 24'd12800));
    send_sample(make_sample(qpgtl_pkg::ModeLaunch, 16'sd15137, 0, -16'sd6270, 0,
                            -16'sd700, 16'sd64, 16'sd2048, 24'sd10240, 24'sd2560,
                            24'd5000));
    // quaternion far from unit length, used as it is
    send_sample(make_sample(qpgtl_pkg::ModeRail, 16'sd100, 16'sd200, -16'sd300, 16'sd400,
                            16'sd1, -16'sd1, 16'sd3, 24'sd5120, 0, 0));
    send_sample(make_sample(qpgtl_pkg::ModeLaunch, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(make_sample(qpgtl_pkg::ModeIdle, 16'sh8000, 16'sh8000, 16'sh8000,
                            16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 24'sh800000,
                            24'sh800000, 24'hffffff));
    send_sample(make_sample(qpgtl_pkg::ModeCoast, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    settle_pipeline();
  endtask

  task automatic test_register_extremes();
    write_reg(qpgtl_pkg::RegAttitudeGain, 32'h0000_ffff);
    write_reg(qpgtl_pkg::RegRateGain, 32'h0000_ffff);
    write_reg(qpgtl_pkg::RegAltitudeGain, 32'h0000_ffff);
    write_reg(qpgtl_pkg::RegClimbRateGain, 32'h0000_ffff);
    write_reg(qpgtl_pkg::RegGravity, 32'h0000_ffff);
    write_reg(qpgtl_pkg::RegTargetAlt, 32'h007f_ffff);
    write_reg(qpgtl_pkg::RegDryMass, 32'h00ff_ffff);
    send_corner_samples();
    settle_pipeline();
    write_reg(qpgtl_pkg::RegAttitudeGain, 32'h0);
    write_reg(qpgtl_pkg::RegRateGain, 32'h0);
    write_reg(qpgtl_pkg::RegAltitudeGain, 32'h0);
    write_reg(qpgtl_pkg::RegClimbRateGain, 32'h0);
    write_reg(qpgtl_pkg::RegGravity, 32'h0);
    write_reg(qpgtl_pkg::RegTargetAlt, 32'hff80_0000);
    write_reg(qpgtl_pkg::RegDryMass, 32'h0);
    send_corner_samples();
    settle_pipeline();
    write_reg(qpgtl_pkg::RegAltitudeGain, 32'h0000_0a00);
    write_reg(qpgtl_pkg::RegTargetAlt, 32'hff80_0000);
    write_reg(qpgtl_pkg::RegAttitudeGain, 32'h0000_ffff);
    // a write past the last register must change nothing
    apb_write(UnmappedAddr, 32'hffff_ffff);
    send_corner_samples();
    settle_pipeline();
  endtask

  task automatic randomize_registers();
    write_reg(qpgtl_pkg::RegAttitudeGain, rand_reg_word(16));
    write_reg(qpgtl_pkg::RegRateGain, rand_reg_word(16));
    write_reg(qpgtl_pkg::RegAltitudeGain, rand_reg_word(16));
    write_reg(qpgtl_pkg::RegClimbRateGain, rand_reg_word(16));
    write_reg(qpgtl_pkg::RegGravity, rand_reg_word(16));
    write_reg(qpgtl_pkg::RegTargetAlt, rand_reg_word(24));
    write_reg(qpgtl_pkg::RegDryMass, rand_reg_word(24));
  endtask

  task automatic test_random_traffic();
    int unsigned gaps[4]   = '{0, 47, 0, 12};
    int unsigned stalls[4] = '{0, 0, 47, 12};
    int unsigned active;
    state_sample_t s;
    for (int ph = 0; ph < 4; ph++) begin
      randomize_registers();
      gap_pct = gaps[ph];
      stall_pct = stalls[ph];
      active = 0;
      while (active < 230) begin
        s = rand_sample();
        if (s.mode != qpgtl_pkg::ModeIdle) active++;
        send_sample(s);
      end
      settle_pipeline();
    end
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    randomize_registers();
    // hold the output long enough to fill every stage and block the input
    hold_cycles = 150;
    repeat (40) send_sample(rand_sample());
    settle_pipeline();
    stall_pct = 30;
    repeat (20) send_sample(rand_sample());
    settle_pipeline();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (qpgtl_pkg::NumStages * 3) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
